>>> rtl/p2rt_pkg.sv
// shared constants and types for the pose to rigid transform block
`default_nettype none
package p2rt_pkg;
    localparam int ANG_W = 36;
    localparam int CRD_W = 34;
    localparam logic signed [ANG_W-1:0] Q30_PI      = 36'sd3373259426;
    localparam logic signed [ANG_W-1:0] Q30_HALF_PI = 36'sd1686629713;
    localparam logic signed [CRD_W-1:0] Q30_GAIN    = 34'sd652032874;

    typedef enum logic {
        t_OP_W2C = 1'b0,
        t_OP_C2W = 1'b1
    } t_op;

    typedef struct packed {
        logic signed [CRD_W-1:0] x;
        logic signed [CRD_W-1:0] y;
        logic signed [ANG_W-1:0] z;
        logic                    neg;
    } t_crd;

    function automatic logic signed [ANG_W-1:0] atan_q30(input int i);
        logic signed [ANG_W-1:0] r;
        case (i)
            0: r = 36'sd843314857;
            1: r = 36'sd497837829;
            2: r = 36'sd263043837;
            3: r = 36'sd133525159;
            4: r = 36'sd67021687;
            5: r = 36'sd33543516;
            6: r = 36'sd16775851;
            7: r = 36'sd8388437;
            8: r = 36'sd4194283;
            9: r = 36'sd2097149;
            10: r = 36'sd1048576;
            default: r = (i < 62) ? ANG_W'($signed(64'sd1073741824 >>> i)) : '0;
        endcase
        return r;
    endfunction
endpackage
`default_nettype wire

>>> rtl/p2rt_cordic_cell.sv
// one rotation-mode cordic iteration, registered
`default_nettype none
module p2rt_cordic_cell #(
    parameter int STAGE = 0
) (
    input  wire logic            i_clk,
    input  wire p2rt_pkg::t_crd  i_d,
    output p2rt_pkg::t_crd       o_d
);
    p2rt_pkg::t_crd r_d, n_d;
    localparam int SH = (STAGE < p2rt_pkg::CRD_W) ? STAGE : p2rt_pkg::CRD_W - 1;
    always_comb begin
        n_d = i_d;
        if (!i_d.z[p2rt_pkg::ANG_W-1]) begin
            n_d.x = i_d.x - (i_d.y >>> SH);
            n_d.y = i_d.y + (i_d.x >>> SH);
            n_d.z = i_d.z - p2rt_pkg::atan_q30(STAGE);
        end else begin
            n_d.x = i_d.x + (i_d.y >>> SH);
            n_d.y = i_d.y - (i_d.x >>> SH);
            n_d.z = i_d.z + p2rt_pkg::atan_q30(STAGE);
        end
    end
    always_ff @(posedge i_clk) begin
        r_d <= n_d;
    end
    assign o_d = r_d;
endmodule
`default_nettype wire

>>> rtl/p2rt_sincos.sv
// sin/cos of a negated q3.13 angle through a chain of cordic cells
`default_nettype none
module p2rt_sincos #(
    parameter int SINCOS_STAGES = 16
) (
    input  wire logic                               i_clk,
    input  wire logic signed [15:0]                 i_ang,
    output logic signed [p2rt_pkg::CRD_W-1:0]       o_sin,
    output logic signed [p2rt_pkg::CRD_W-1:0]       o_cos
);
    p2rt_pkg::t_crd chain [SINCOS_STAGES+1];
    p2rt_pkg::t_crd r_in, n_in;
    logic signed [p2rt_pkg::ANG_W-1:0] a;

    always_comb begin
        a = -(p2rt_pkg::ANG_W'(i_ang) <<< 17);
        n_in.x = p2rt_pkg::Q30_GAIN;
        n_in.y = '0;
        n_in.z = a;
        n_in.neg = 1'b0;
        if (a > p2rt_pkg::Q30_HALF_PI) begin
            n_in.z = a - p2rt_pkg::Q30_PI;
            n_in.neg = 1'b1;
        end else if (a < -p2rt_pkg::Q30_HALF_PI) begin
            n_in.z = a + p2rt_pkg::Q30_PI;
            n_in.neg = 1'b1;
        end
    end
    always_ff @(posedge i_clk) begin
        r_in <= n_in;
    end
    assign chain[0] = r_in;

    for (genvar g = 0; g < SINCOS_STAGES; g++) begin : g_cell
        p2rt_cordic_cell #(.STAGE(g)) u_cell (
            .i_clk(i_clk), .i_d(chain[g]), .o_d(chain[g+1])
        );
    end

    assign o_sin = chain[SINCOS_STAGES].neg ? -chain[SINCOS_STAGES].y
                                            : chain[SINCOS_STAGES].y;
    assign o_cos = chain[SINCOS_STAGES].neg ? -chain[SINCOS_STAGES].x
                                            : chain[SINCOS_STAGES].x;
endmodule
`default_nettype wire

>>> rtl/pose_to_rigid_transform.sv
// top level: pose to rigid transform, cordic chains and product pipeline
// path from accepted request to o_valid: sincos input register, cordic cells, stages a to d, output register
// throughput: one request per cycle, busy is never raised
// the receiver cannot stall; each result strobes o_valid for one cycle
// reset (synchronous, active low) clears the valid pipeline only
// datapath registers carry no reset
`default_nettype none
module pose_to_rigid_transform #(
    parameter int ROT_FRAC_BITS = 14,
    parameter int SINCOS_STAGES = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               i_opcode,
    input  wire logic signed [31:0] i_position_x,
    input  wire logic signed [31:0] i_position_y,
    input  wire logic signed [31:0] i_position_z,
    input  wire logic signed [15:0] i_roll_angle,
    input  wire logic signed [15:0] i_pitch_angle,
    input  wire logic signed [15:0] i_yaw_angle,
    output logic                    o_valid,
    output logic signed [15:0]      o_rot_00,
    output logic signed [15:0]      o_rot_01,
    output logic signed [15:0]      o_rot_02,
    output logic signed [15:0]      o_rot_10,
    output logic signed [15:0]      o_rot_11,
    output logic signed [15:0]      o_rot_12,
    output logic signed [15:0]      o_rot_20,
    output logic signed [15:0]      o_rot_21,
    output logic signed [15:0]      o_rot_22,
    output logic signed [31:0]      o_trans_x,
    output logic signed [31:0]      o_trans_y,
    output logic signed [31:0]      o_trans_z
);
    localparam int CW  = p2rt_pkg::CRD_W;
    localparam int LAT = SINCOS_STAGES + 1;   // sincos input reg plus cells
    localparam int TOT = LAT + 5;
    localparam int RSH = 30 - ROT_FRAC_BITS;
    localparam logic signed [67:0] HALF30 = 68'sd1 <<< 29;

    assign busy = 1'b0;

    // valid and side-band delay line, one entry per pipeline stage
    logic [TOT-1:0] r_vld;
    logic           r_op  [TOT];
    logic signed [31:0] r_p [TOT][3];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[TOT-2:0], start};
        end
    end
    always_ff @(posedge i_clk) begin
        r_op[0] <= i_opcode;
        r_p[0][0] <= i_position_x;
        r_p[0][1] <= i_position_y;
        r_p[0][2] <= i_position_z;
        for (int k = 1; k < TOT; k++) begin
            r_op[k] <= r_op[k-1];
            r_p[k] <= r_p[k-1];
        end
    end

    // sin/cos of roll, pitch, yaw
    logic signed [CW-1:0] sx, cx, sy, cy, sz, cz;
    p2rt_sincos #(.SINCOS_STAGES(SINCOS_STAGES)) u_sx (
        .i_clk(i_clk), .i_ang(i_roll_angle), .o_sin(sx), .o_cos(cx));
    p2rt_sincos #(.SINCOS_STAGES(SINCOS_STAGES)) u_sy (
        .i_clk(i_clk), .i_ang(i_pitch_angle), .o_sin(sy), .o_cos(cy));
    p2rt_sincos #(.SINCOS_STAGES(SINCOS_STAGES)) u_sz (
        .i_clk(i_clk), .i_ang(i_yaw_angle), .o_sin(sz), .o_cos(cz));

    function automatic logic signed [CW-1:0] rnd30(input logic signed [67:0] v);
        logic signed [67:0] t;
        t = (v + HALF30) >>> 30;
        return t[CW-1:0];
    endfunction

    function automatic logic signed [15:0] rot_out(input logic signed [CW-1:0] v);
        logic signed [CW:0] t;
        logic signed [CW:0] lim;
        lim = (CW+1)'(1) <<< ROT_FRAC_BITS;
        if (RSH > 0) t = ((CW+1)'(v) + ((CW+1)'(1) <<< (RSH > 0 ? RSH-1 : 0))) >>> RSH;
        else t = (CW+1)'(v);
        if (t > lim) t = lim;
        if (t < -lim) t = -lim;
        if (t > 32767) t = 32767;
        if (t < -32768) t = -32768;
        return t[15:0];
    endfunction

    // stage a: first products
    logic signed [CW-1:0] r_czsy, r_szsy, r_czcy, r_szcy, r_cysx, r_cycx;
    logic signed [CW-1:0] r_sx, r_cx, r_sy, r_sz, r_cz;
    always_ff @(posedge i_clk) begin
        r_czsy <= rnd30(68'(cz) * 68'(sy));
        r_szsy <= rnd30(68'(sz) * 68'(sy));
        r_czcy <= rnd30(68'(cz) * 68'(cy));
        r_szcy <= rnd30(68'(sz) * 68'(cy));
        r_cysx <= rnd30(68'(cy) * 68'(sx));
        r_cycx <= rnd30(68'(cy) * 68'(cx));
        r_sx <= sx; r_cx <= cx; r_sy <= sy; r_sz <= sz; r_cz <= cz;
    end

    // stage b: second products, kept exact
    logic signed [67:0] r_m [8];
    logic signed [CW-1:0] r_b00, r_b10, r_b21, r_b22, r_nsy;
    always_ff @(posedge i_clk) begin
        r_m[0] <= 68'(r_czsy) * 68'(r_sx);
        r_m[1] <= 68'(r_sz) * 68'(r_cx);
        r_m[2] <= 68'(r_czsy) * 68'(r_cx);
        r_m[3] <= 68'(r_sz) * 68'(r_sx);
        r_m[4] <= 68'(r_szsy) * 68'(r_sx);
        r_m[5] <= 68'(r_cz) * 68'(r_cx);
        r_m[6] <= 68'(r_szsy) * 68'(r_cx);
        r_m[7] <= 68'(r_cz) * 68'(r_sx);
        r_b00 <= r_czcy; r_b10 <= r_szcy; r_b21 <= r_cysx; r_b22 <= r_cycx;
        r_nsy <= -r_sy;
    end

    // stage c: sums and output rounding
    logic signed [15:0] r_r [3][3];
    always_ff @(posedge i_clk) begin
        r_r[0][0] <= rot_out(r_b00);
        r_r[0][1] <= rot_out(rnd30(r_m[0] - r_m[1]));
        r_r[0][2] <= rot_out(rnd30(r_m[2] + r_m[3]));
        r_r[1][0] <= rot_out(r_b10);
        r_r[1][1] <= rot_out(rnd30(r_m[4] + r_m[5]));
        r_r[1][2] <= rot_out(rnd30(r_m[6] - r_m[7]));
        r_r[2][0] <= rot_out(r_nsy);
        r_r[2][1] <= rot_out(r_b21);
        r_r[2][2] <= rot_out(r_b22);
    end

    // stage d: rotation times position products
    localparam int PD = LAT + 3;
    logic signed [47:0] r_rp [3][3];
    logic signed [15:0] r_rd [3][3];
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                r_rp[i][j] <= 48'(r_r[i][j]) * 48'(r_p[PD-1][j]);
            end
        end
        r_rd <= r_r;
    end

    // stage e: sum, negate, round, saturate, select
    logic signed [50:0] acc [3];
    logic signed [50:0] rnd [3];
    logic signed [31:0] tr [3];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            acc[i] = -(51'(r_rp[i][0]) + 51'(r_rp[i][1]) + 51'(r_rp[i][2]));
            rnd[i] = (acc[i] + (51'sd1 <<< (ROT_FRAC_BITS-1))) >>> ROT_FRAC_BITS;
            if (rnd[i] > 51'sd2147483647) tr[i] = 32'sh7FFFFFFF;
            else if (rnd[i] < -51'sd2147483648) tr[i] = 32'sh80000000;
            else tr[i] = rnd[i][31:0];
        end
    end

    logic signed [15:0] r_o [3][3];
    logic signed [31:0] r_t [3];
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                r_o[i][j] <= (r_op[TOT-2] == p2rt_pkg::t_OP_C2W) ? r_rd[j][i] : r_rd[i][j];
            end
            r_t[i] <= (r_op[TOT-2] == p2rt_pkg::t_OP_C2W) ? r_p[TOT-2][i] : tr[i];
        end
    end

    assign o_valid = r_vld[TOT-1];
    assign o_rot_00 = r_o[0][0];
    assign o_rot_01 = r_o[0][1];
    assign o_rot_02 = r_o[0][2];
    assign o_rot_10 = r_o[1][0];
    assign o_rot_11 = r_o[1][1];
    assign o_rot_12 = r_o[1][2];
    assign o_rot_20 = r_o[2][0];
    assign o_rot_21 = r_o[2][1];
    assign o_rot_22 = r_o[2][2];
    assign o_trans_x = r_t[0];
    assign o_trans_y = r_t[1];
    assign o_trans_z = r_t[2];

    // output strobe follows the request strobe by the fixed latency
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[TOT-2] |=> o_valid) else $error("lost result");
    a_inv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && r_op[TOT-1] == p2rt_pkg::t_OP_C2W |-> o_trans_x == r_p[TOT-1][0])
        else $error("inverse translation mismatch");
    a_rot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (int'(o_rot_20) <= (1 <<< ROT_FRAC_BITS)) &&
                    (int'(o_rot_20) >= -(1 <<< ROT_FRAC_BITS)))
        else $error("rotation entry out of range");
endmodule
`default_nettype wire

>>> test/tb.sv
// testbench for pose_to_rigid_transform: table-driven and random poses against a predictor
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROT_FRAC = 14;
    localparam int STAGES = 16;
    localparam int LATENCY = STAGES + 6;
    localparam int RANDOM_POSES = 850;
    localparam int STALL_LIMIT = 1000;
    localparam longint GAIN_Q30 = 64'sd652032874;
    localparam longint PI_Q30 = 64'sd3373259426;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam logic signed [15:0] ONE_ROT = 16'sd16384;
    localparam p2rt_pkg::t_op OP_W2C = p2rt_pkg::t_OP_W2C;
    localparam p2rt_pkg::t_op OP_C2W = p2rt_pkg::t_OP_C2W;

    // one transform as it leaves the block
    typedef struct {
        logic signed [15:0] rot [9];
        logic signed [31:0] trans [3];
    } t_transform;

    // one row of the directed table; typed rows carry their answer
    typedef struct {
        p2rt_pkg::t_op op;
        logic signed [31:0] px, py, pz;
        logic signed [15:0] roll, pitch, yaw;
        bit typed;
        t_transform answer;
    } t_pose_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic i_opcode = 1'b0;
    logic signed [31:0] i_position_x = '0, i_position_y = '0, i_position_z = '0;
    logic signed [15:0] i_roll_angle = '0, i_pitch_angle = '0, i_yaw_angle = '0;
    logic o_valid;
    logic signed [15:0] o_rot_00, o_rot_01, o_rot_02, o_rot_10, o_rot_11, o_rot_12;
    logic signed [15:0] o_rot_20, o_rot_21, o_rot_22;
    logic signed [31:0] o_trans_x, o_trans_y, o_trans_z;

    t_transform pending_transforms [$];
    int mismatch_count = 0;
    int stall_cycles = 0;
    t_pose_row pose_table [$];

    pose_to_rigid_transform #(.ROT_FRAC_BITS(ROT_FRAC), .SINCOS_STAGES(STAGES)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_opcode(i_opcode), .i_position_x(i_position_x), .i_position_y(i_position_y),
        .i_position_z(i_position_z), .i_roll_angle(i_roll_angle),
        .i_pitch_angle(i_pitch_angle), .i_yaw_angle(i_yaw_angle),
        .o_valid(o_valid), .o_rot_00(o_rot_00), .o_rot_01(o_rot_01), .o_rot_02(o_rot_02),
        .o_rot_10(o_rot_10), .o_rot_11(o_rot_11), .o_rot_12(o_rot_12),
        .o_rot_20(o_rot_20), .o_rot_21(o_rot_21), .o_rot_22(o_rot_22),
        .o_trans_x(o_trans_x), .o_trans_y(o_trans_y), .o_trans_z(o_trans_z)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // q30 product rounded half up
    function automatic longint mul_round(input longint a, input longint b);
        return (a * b + (longint'(1) <<< 29)) >>> 30;
    endfunction

    // arctangent steps in q30; past stage ten the small-angle value is used
    function automatic longint p2rt_angle_step(input int i);
        longint steps [11] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                               33543516, 16775851, 8388437, 4194283, 2097149, 1048576};
        return (i < 11) ? steps[i] : (longint'(1) <<< 30) >>> i;
    endfunction

    // cordic in rotation mode, angle is the raw q3.13 input (negated here)
    function automatic void cordic_sincos(input logic signed [15:0] raw,
                                          output longint s, output longint c);
        longint x, y, z, nx, ny, step;
        bit flip;
        x = GAIN_Q30;
        y = 0;
        z = -longint'(raw) * 131072;
        flip = 0;
        // fold into +-pi/2, flipping both outputs
        if (z > HALF_PI_Q30) begin
            z -= PI_Q30;
            flip = 1;
        end else if (z < -HALF_PI_Q30) begin
            z += PI_Q30;
            flip = 1;
        end
        for (int i = 0; i < STAGES; i++) begin
            step = p2rt_angle_step(i);
            if (z >= 0) begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z -= step;
            end else begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z += step;
            end
            x = nx;
            y = ny;
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endfunction

    // q30 entry to rotation format, clamped to +-1
    function automatic longint to_rot(input longint v);
        longint lim;
        lim = longint'(1) <<< ROT_FRAC;
        v = (v + (longint'(1) <<< (29 - ROT_FRAC))) >>> (30 - ROT_FRAC);
        if (v > lim) v = lim;
        if (v < -lim) v = -lim;
        return v;
    endfunction

    function automatic t_transform pose_transform(input t_pose_row pose);
        t_transform t;
        longint sx, cx, sy, cy, sz, cz, czsy, szsy, acc;
        longint r [3][3];
        longint p [3];
        cordic_sincos(pose.roll, sx, cx);
        cordic_sincos(pose.pitch, sy, cy);
        cordic_sincos(pose.yaw, sz, cz);
        p[0] = pose.px;
        p[1] = pose.py;
        p[2] = pose.pz;
        czsy = mul_round(cz, sy);
        szsy = mul_round(sz, sy);
        r[0][0] = to_rot(mul_round(cz, cy));
        r[0][1] = to_rot((czsy * sx - sz * cx + (longint'(1) <<< 29)) >>> 30);
        r[0][2] = to_rot((czsy * cx + sz * sx + (longint'(1) <<< 29)) >>> 30);
        r[1][0] = to_rot(mul_round(sz, cy));
        r[1][1] = to_rot((szsy * sx + cz * cx + (longint'(1) <<< 29)) >>> 30);
        r[1][2] = to_rot((szsy * cx - cz * sx + (longint'(1) <<< 29)) >>> 30);
        r[2][0] = to_rot(-sy);
        r[2][1] = to_rot(mul_round(cy, sx));
        r[2][2] = to_rot(mul_round(cy, cx));
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++)
                t.rot[i*3+j] = 16'(pose.op == OP_C2W ? r[j][i] : r[i][j]);
            if (pose.op == OP_C2W) begin
                t.trans[i] = 32'(p[i]);
            end else begin
                // -R*p, rounded back to q16.16 and saturated
                acc = -(r[i][0] * p[0] + r[i][1] * p[1] + r[i][2] * p[2]);
                acc = (acc + (longint'(1) <<< (ROT_FRAC - 1))) >>> ROT_FRAC;
                if (acc > 64'sd2147483647) acc = 64'sd2147483647;
                if (acc < -64'sd2147483648) acc = -64'sd2147483648;
                t.trans[i] = 32'(acc);
            end
        end
        return t;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("t=%0t %s: got %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // result side: compare against the oldest expected transform
    always @(posedge i_clk) begin
        t_transform want;
        logic signed [15:0] got_rot [9];
        logic signed [31:0] got_trans [3];
        if (i_rst_n && o_valid) begin
            got_rot = '{o_rot_00, o_rot_01, o_rot_02, o_rot_10, o_rot_11, o_rot_12,
                        o_rot_20, o_rot_21, o_rot_22};
            got_trans = '{o_trans_x, o_trans_y, o_trans_z};
            if (pending_transforms.size() == 0) begin
                report_mismatch("result with no request outstanding", 0, 0);
            end else begin
                want = pending_transforms.pop_front();
                for (int k = 0; k < 9; k++)
                    if (got_rot[k] !== want.rot[k])
                        report_mismatch($sformatf("rot_%0d%0d", k / 3, k % 3),
                                        got_rot[k], want.rot[k]);
                for (int k = 0; k < 3; k++)
                    if (got_trans[k] !== want.trans[k])
                        report_mismatch($sformatf("trans %0d", k), got_trans[k],
                                        want.trans[k]);
            end
        end
    end

    // watchdog: cycles with neither a request nor a result taken
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // idle the request side for a random spell, mostly short
    task automatic idle_requests(input bit allow);
        int n, pick;
        pick = $urandom_range(0, 99);
        if (!allow || pick < 65) n = 0;
        else if (pick < 94) n = $urandom_range(1, 3);
        else n = $urandom_range(8, 40);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // present one pose and hold it until taken
    task automatic send_pose(input t_pose_row pose);
        start <= 1'b1;
        i_opcode <= pose.op;
        i_position_x <= pose.px;
        i_position_y <= pose.py;
        i_position_z <= pose.pz;
        i_roll_angle <= pose.roll;
        i_pitch_angle <= pose.pitch;
        i_yaw_angle <= pose.yaw;
        do @(posedge i_clk); while (busy);
        pending_transforms.push_back(pose.typed ? pose.answer : pose_transform(pose));
    endtask

    function automatic t_pose_row make_row(input p2rt_pkg::t_op op,
                                           input logic signed [31:0] px, py, pz,
                                           input logic signed [15:0] roll, pitch, yaw);
        t_pose_row row;
        row.op = op;
        row.px = px;
        row.py = py;
        row.pz = pz;
        row.roll = roll;
        row.pitch = pitch;
        row.yaw = yaw;
        row.typed = 0;
        return row;
    endfunction

    // zero angles give the identity, so the answer is plain
    function automatic t_pose_row identity_row(input p2rt_pkg::t_op op,
                                               input logic signed [31:0] px, py, pz,
                                               input logic signed [31:0] tx, ty, tz);
        t_pose_row row;
        row = make_row(op, px, py, pz, '0, '0, '0);
        row.typed = 1;
        row.answer.rot = '{ONE_ROT, 0, 0, 0, ONE_ROT, 0, 0, 0, ONE_ROT};
        row.answer.trans = '{tx, ty, tz};
        return row;
    endfunction

    function automatic logic signed [31:0] random_position();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 5) return $urandom;
        if (pick < 8) return $signed(32'($urandom_range(0, 32'h00ff_ffff))) - 32'sh0080_0000;
        return pick == 8 ? 32'sh7fff_ffff : 32'sh8000_0000;
    endfunction

    function automatic logic signed [15:0] random_angle();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0) return 16'sh7fff;
        if (pick == 1) return 16'sh8000;
        if (pick == 2) return 16'($urandom_range(12866, 12870));
        if (pick == 3) return -16'($urandom_range(12866, 12870));
        return 16'($urandom);
    endfunction

    localparam logic signed [31:0] PMAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] PMIN = 32'sh8000_0000;

    initial begin
        t_pose_row row;
        bit burst;
        // directed table: identity, extremes, fold boundaries, saturation
        pose_table.push_back(identity_row(OP_W2C, 0, 0, 0, 0, 0, 0));
        pose_table.push_back(identity_row(OP_W2C, 32'sh10000, 32'sh20000, -32'sh30000,
                                          -32'sh10000, -32'sh20000, 32'sh30000));
        pose_table.push_back(identity_row(OP_W2C, PMIN, PMAX, 0, PMAX, -PMAX, 0));
        pose_table.push_back(identity_row(OP_C2W, PMIN, PMAX, 32'sh1234_5678,
                                          PMIN, PMAX, 32'sh1234_5678));
        pose_table.push_back(identity_row(OP_C2W, 0, -1, 1, 0, -1, 1));
        pose_table.push_back(make_row(OP_W2C, PMAX, PMAX, PMAX,
                                      16'sh7fff, 16'sh7fff, 16'sh7fff));
        pose_table.push_back(make_row(OP_W2C, PMIN, PMIN, PMIN,
                                      16'sh8000, 16'sh8000, 16'sh8000));
        pose_table.push_back(make_row(OP_C2W, PMAX, PMIN, 0, 16'sh8000, 16'sh7fff, '0));
        pose_table.push_back(make_row(OP_W2C, PMIN, PMAX, PMIN,
                                      16'sd12868, -16'sd12868, 16'sd12867));
        pose_table.push_back(make_row(OP_W2C, 32'sh0001_0000, 0, 0,
                                      -16'sd12867, 16'sd12868, -16'sd12868));
        pose_table.push_back(make_row(OP_C2W, -5, 7, 9,
                                      16'sd12867, 16'sd12868, -16'sd12867));
        pose_table.push_back(make_row(OP_W2C, 32'sh0003_0000, -32'sh0002_0000, 32'sh0001_0000,
                                      16'sd6434, -16'sd6434, 16'sd25736));
        pose_table.push_back(make_row(OP_W2C, PMAX, PMAX, PMAX, '0, 16'sd12868, '0));
        pose_table.push_back(make_row(OP_W2C, PMIN, PMIN, PMIN, 16'sd6434, '0, 16'sd6434));
        pose_table.push_back(make_row(OP_C2W, 1, 2, 3, 16'sh7fff, '0, 16'sh8000));

        // hold reset low, then release it
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (pose_table[k]) begin
            idle_requests(k % 4 != 0);
            send_pose(pose_table[k]);
        end

        burst = 0;
        for (int n = 0; n < RANDOM_POSES; n++) begin
            // every 50 poses, pick at random a run of back-to-back requests or a run with gaps
            if (n % 50 == 0) burst = ($urandom_range(0, 2) == 0);
            // let the pipeline drain once in the middle
            if (n == RANDOM_POSES / 2) begin
                start <= 1'b0;
                while (pending_transforms.size() != 0) @(posedge i_clk);
            end
            idle_requests(!burst);
            row = make_row(p2rt_pkg::t_op'($urandom_range(0, 1)), random_position(),
                           random_position(), random_position(), random_angle(),
                           random_angle(), random_angle());
            send_pose(row);
        end
        start <= 1'b0;

        while (pending_transforms.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
